[hw/rtl/tmr_od_pkg.sv]
// Shared types, codes and constant tables of the triple-redundant object dictionary.
`default_nettype none
package tmr_od_pkg;

	localparam int IDX_W        = 7;
	localparam int DATA_W       = 32;
	localparam int ENTRY_COUNT  = 99;
	localparam int TABLE_ROWS   = 99;
	localparam int MAX_ENTRIES  = 128;

	typedef enum logic [2:0] {
		OP_RAW_WRITE = 3'd0,
		OP_RAW_READ  = 3'd1,
		OP_NET_WRITE = 3'd2,
		OP_NET_READ  = 3'd3,
		OP_TIME_SET  = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		RIGHT_NONE       = 3'd0,
		RIGHT_GET        = 3'd1,
		RIGHT_SET        = 3'd2,
		RIGHT_GET_AND_SET = 3'd3,
		RIGHT_SETT       = 3'd4
	} right_t;

	typedef enum logic [1:0] {
		MARK_UNTOUCHED = 2'd0,
		MARK_CHANGED   = 2'd1,
		MARK_WRITTEN   = 2'd2
	} mark_t;

	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_BAD_RIGHT = 2'd1,
		STATUS_BAD_INDEX = 2'd2
	} status_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_EXEC = 1'b1
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;    // capture transaction, launch memory read
		logic commit;  // vote, write back, register result
	} cmd_t;

	localparam logic [2:0] SIZE_CODE [TABLE_ROWS] = '{
		3'd3,3'd5,3'd6,3'd6,3'd6,3'd6,3'd6,3'd6,3'd6,3'd3,
		3'd3,3'd6,3'd0,3'd0,3'd0,3'd0,3'd3,3'd3,3'd3,3'd3,
		3'd6,3'd3,3'd6,3'd3,3'd3,3'd6,3'd3,3'd3,3'd3,3'd3,
		3'd3,3'd3,3'd3,3'd6,3'd3,3'd5,3'd3,3'd3,3'd3,3'd3,
		3'd6,3'd6,3'd6,3'd6,3'd3,3'd6,3'd6,3'd6,3'd6,3'd3,
		3'd3,3'd3,3'd3,3'd3,3'd3,3'd3,3'd3,3'd3,3'd3,3'd3,
		3'd3,3'd3,3'd3,3'd3,3'd3,3'd3,3'd3,3'd3,3'd3,3'd3,
		3'd3,3'd3,3'd6,3'd3,3'd3,3'd6,3'd6,3'd6,3'd6,3'd6,
		3'd6,3'd6,3'd6,3'd6,3'd4,3'd4,3'd6,3'd4,3'd4,3'd4,
		3'd4,3'd4,3'd4,3'd4,3'd4,3'd4,3'd4,3'd4,3'd4
	};

	localparam logic [2:0] ACCESS_RIGHT [TABLE_ROWS] = '{
		3'd1,3'd4,3'd4,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,
		3'd1,3'd1,3'd2,3'd1,3'd1,3'd1,3'd3,3'd3,3'd3,3'd3,
		3'd3,3'd3,3'd3,3'd3,3'd3,3'd3,3'd3,3'd3,3'd3,3'd3,
		3'd3,3'd3,3'd3,3'd3,3'd3,3'd3,3'd3,3'd3,3'd3,3'd3,
		3'd3,3'd3,3'd3,3'd3,3'd3,3'd3,3'd3,3'd3,3'd3,3'd1,
		3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,
		3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,
		3'd1,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,
		3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,
		3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2
	};

	function automatic logic [DATA_W-1:0] swap_bytes(input logic [DATA_W-1:0] x);
		return {x[7:0], x[15:8], x[23:16], x[31:24]};
	endfunction

	function automatic logic [DATA_W-1:0] mask_of(input logic [IDX_W-1:0] idx);
		logic [DATA_W-1:0] m;
		m = 32'hFFFF_FFFF;
		if (int'(idx) < TABLE_ROWS) begin
			case (SIZE_CODE[idx])
				3'd0:    m = 32'h0000_0001;
				3'd1:    m = 32'h0000_0003;
				3'd2:    m = 32'h0000_0007;
				3'd3:    m = 32'h0000_00FF;
				3'd4:    m = 32'h0000_FFFF;
				3'd5:    m = 32'h00FF_FFFF;
				default: m = 32'hFFFF_FFFF;
			endcase
		end
		return m;
	endfunction

	function automatic right_t right_of(input logic [IDX_W-1:0] idx);
		right_t r;
		r = RIGHT_NONE;
		if (int'(idx) < TABLE_ROWS) begin
			r = right_t'(ACCESS_RIGHT[idx]);
		end
		return r;
	endfunction

	// power-up contents of an entry
	function automatic logic [DATA_W-1:0] default_of(input logic [IDX_W-1:0] idx);
		logic [DATA_W-1:0] v;
		case (idx)
			7'h00:   v = 32'd102;
			7'h10:   v = 32'd1;
			7'h1B:   v = 32'd3;
			7'h1E:   v = 32'd1;
			7'h1F:   v = 32'd1;
			7'h25:   v = 32'd10;
			7'h26:   v = 32'd120;
			7'h27:   v = 32'd1;
			7'h30:   v = 32'd30;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

[hw/rtl/tmr_od_ctrl.sv]
// Transaction sequencer of the object dictionary: load cycle, then execute cycle.
`default_nettype none
module tmr_od_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	output tmr_od_pkg::cmd_t       cmd
);

	tmr_od_pkg::state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tmr_od_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			tmr_od_pkg::ST_IDLE: begin
				if (start) state_nxt = tmr_od_pkg::ST_EXEC;
			end
			tmr_od_pkg::ST_EXEC: begin
				state_nxt = tmr_od_pkg::ST_IDLE;
			end
			default: state_nxt = tmr_od_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		busy       = 1'b0;
		cmd.load   = 1'b0;
		cmd.commit = 1'b0;
		unique case (state_q)
			tmr_od_pkg::ST_IDLE: begin
				cmd.load = start;
			end
			tmr_od_pkg::ST_EXEC: begin
				busy       = 1'b1;
				cmd.commit = 1'b1;
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

[hw/rtl/tmr_od_datapath.sv]
// Entry memories, two-of-three voter, access checks and result registers.
`default_nettype none
module tmr_od_datapath #(
	parameter int ENTRY_COUNT = tmr_od_pkg::ENTRY_COUNT
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire tmr_od_pkg::cmd_t                  cmd,
	input  wire logic [2:0]                        op,
	input  wire logic [tmr_od_pkg::IDX_W-1:0]      index,
	input  wire logic [tmr_od_pkg::DATA_W-1:0]     write_data,
	output logic                                   done,
	output logic [1:0]                             status,
	output logic [tmr_od_pkg::DATA_W-1:0]          read_data,
	output logic [1:0]                             entry_state,
	output logic                                   vote_failed
);

	localparam int IW = tmr_od_pkg::IDX_W;
	localparam int DW = tmr_od_pkg::DATA_W;
	localparam int AW = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
	localparam logic [IW:0] COUNT = (IW + 1)'(ENTRY_COUNT);

	logic [DW-1:0] mem_a [ENTRY_COUNT];
	logic [DW-1:0] mem_b [ENTRY_COUNT];
	logic [DW-1:0] mem_c [ENTRY_COUNT];
	logic [1:0]    mem_m [ENTRY_COUNT];
	logic [ENTRY_COUNT-1:0] vld_q;  // entry has been written since reset

	logic [2:0]    op_q;
	logic [IW-1:0] idx_q;
	logic [DW-1:0] data_q;
	logic [DW-1:0] rd_a_s1, rd_b_s1, rd_c_s1;
	logic [1:0]    rd_m_s1;

	logic [AW-1:0] rd_addr, addr_q;
	assign rd_addr = index[AW-1:0];
	assign addr_q  = idx_q[AW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= op;
			idx_q   <= index;
			data_q  <= write_data;
			rd_a_s1 <= mem_a[rd_addr];
			rd_b_s1 <= mem_b[rd_addr];
			rd_c_s1 <= mem_c[rd_addr];
			rd_m_s1 <= mem_m[rd_addr];
		end
	end

	// execute cycle
	logic            idx_ok, ent_vld;
	logic [DW-1:0]   a, b, c, voted, a_after, swapped, mask;
	logic [1:0]      mark;
	logic            eq_ab, eq_ac, eq_bc, fail;
	tmr_od_pkg::right_t r;
	logic            we;
	logic [DW-1:0]   wa, wb, wc;
	logic [1:0]      wm;
	logic [1:0]      st_n;
	logic [DW-1:0]   rd_n;
	logic            fail_n;

	assign idx_ok  = {1'b0, idx_q} < COUNT;
	assign ent_vld = idx_ok && vld_q[addr_q];
	assign a    = ent_vld ? rd_a_s1 : tmr_od_pkg::default_of(idx_q);
	assign b    = ent_vld ? rd_b_s1 : tmr_od_pkg::default_of(idx_q);
	assign c    = ent_vld ? rd_c_s1 : tmr_od_pkg::default_of(idx_q);
	assign mark = ent_vld ? rd_m_s1 : tmr_od_pkg::MARK_UNTOUCHED;

	assign eq_ab = (a == b);
	assign eq_ac = (a == c);
	assign eq_bc = (b == c);
	assign fail  = !(eq_ab || eq_ac || eq_bc);
	assign voted = (eq_ab || eq_ac) ? a : b;
	assign a_after = fail ? a : voted;

	assign r       = tmr_od_pkg::right_of(idx_q);
	assign mask    = tmr_od_pkg::mask_of(idx_q);
	assign swapped = tmr_od_pkg::swap_bytes(data_q);

	always_comb begin
		we     = 1'b0;
		wa     = fail ? a : voted;
		wb     = fail ? b : voted;
		wc     = fail ? c : voted;
		wm     = mark;
		st_n   = tmr_od_pkg::STATUS_OK;
		rd_n   = '0;
		fail_n = 1'b0;
		if (!idx_ok && op_q <= tmr_od_pkg::OP_TIME_SET) begin
			st_n = tmr_od_pkg::STATUS_BAD_INDEX;
		end else begin
			case (op_q)
				tmr_od_pkg::OP_RAW_WRITE: begin
					we = 1'b1;
					wa = data_q;
					wb = data_q;
					wc = data_q;
				end
				tmr_od_pkg::OP_RAW_READ: begin
					we     = 1'b1;
					fail_n = fail;
					rd_n   = a_after & mask;
				end
				tmr_od_pkg::OP_NET_WRITE, tmr_od_pkg::OP_TIME_SET: begin
					if (r == tmr_od_pkg::RIGHT_NONE) begin
						st_n = tmr_od_pkg::STATUS_BAD_INDEX;
					end else if ((op_q == tmr_od_pkg::OP_NET_WRITE &&
							!(r == tmr_od_pkg::RIGHT_SET ||
							  r == tmr_od_pkg::RIGHT_GET_AND_SET)) ||
							(op_q == tmr_od_pkg::OP_TIME_SET &&
							 r != tmr_od_pkg::RIGHT_SETT)) begin
						st_n = tmr_od_pkg::STATUS_BAD_RIGHT;
					end else begin
						we     = 1'b1;
						fail_n = fail;
						wa     = swapped;
						wb     = swapped;
						wc     = swapped;
						if (a_after != swapped) begin
							wm = tmr_od_pkg::MARK_CHANGED;
						end else if (mark != tmr_od_pkg::MARK_CHANGED) begin
							wm = tmr_od_pkg::MARK_WRITTEN;
						end
					end
				end
				tmr_od_pkg::OP_NET_READ: begin
					if (r == tmr_od_pkg::RIGHT_NONE) begin
						st_n = tmr_od_pkg::STATUS_BAD_INDEX;
					end else if (r != tmr_od_pkg::RIGHT_GET &&
							r != tmr_od_pkg::RIGHT_GET_AND_SET) begin
						st_n = tmr_od_pkg::STATUS_BAD_RIGHT;
					end else begin
						we     = 1'b1;
						fail_n = fail;
						rd_n   = tmr_od_pkg::swap_bytes(a_after);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && we) begin
			mem_a[addr_q] <= wa;
			mem_b[addr_q] <= wb;
			mem_c[addr_q] <= wc;
			mem_m[addr_q] <= wm;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= cmd.commit;
			if (cmd.commit && we) vld_q[addr_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status      <= st_n;
			read_data   <= rd_n;
			entry_state <= idx_ok ? wm : 2'(tmr_od_pkg::MARK_UNTOUCHED);
			vote_failed <= fail_n;
		end
	end

endmodule
`default_nettype wire

[hw/rtl/tmr_object_dictionary.sv]
// Top level of the triple-redundant object dictionary.
//
// Command channel: an op, index and write_data transaction is taken on a rising
// edge where start is high and busy is low. busy is high for the one cycle that
// follows, while the entry's three copies, read from on-chip memory at the
// accept edge, are voted, checked and written back through the single write port.
// The result (status, read_data, entry_state, vote_failed) appears on the
// cycle after that, marked by done for exactly one cycle; the receiver cannot
// stall, so it must take the result in that cycle.
// No new transaction is taken while busy is high, during the read then
// write-back of the entry memories. A new start may be given in the cycle
// in which done is high.
// Reset (arst_n low) clears the controller and the per-entry written flags,
// so every entry reads its default value and an untouched mark again at once;
// no clearing pass is run.
`default_nettype none
module tmr_object_dictionary #(
	parameter int ENTRY_COUNT = tmr_od_pkg::ENTRY_COUNT
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic [2:0]                        op,
	input  wire logic [tmr_od_pkg::IDX_W-1:0]      index,
	input  wire logic [tmr_od_pkg::DATA_W-1:0]     write_data,
	output logic                                   done,
	output logic [1:0]                             status,
	output logic [tmr_od_pkg::DATA_W-1:0]          read_data,
	output logic [1:0]                             entry_state,
	output logic                                   vote_failed
);

	tmr_od_pkg::cmd_t cmd;

	tmr_od_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd)
	);

	tmr_od_datapath #(
		.ENTRY_COUNT (ENTRY_COUNT)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.op          (op),
		.index       (index),
		.write_data  (write_data),
		.done        (done),
		.status      (status),
		.read_data   (read_data),
		.entry_state (entry_state),
		.vote_failed (vote_failed)
	);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after accepted transaction");

	a_exec_one: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !busy && done)
		else $error("execute cycle not followed by a single done");

	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("done without preceding execute cycle");

	a_bad_index: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == tmr_od_pkg::STATUS_BAD_INDEX |->
			read_data == '0 && !vote_failed && entry_state == 2'd0)
		else $error("invalid index result carries data");

endmodule
`default_nettype wire

[dv/tmr_od_result_check.sv]
// Result checker for the object dictionary: mirrors the entries and compares every result.
module tmr_od_result_check (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic                          busy,
	input  wire logic [2:0]                    op,
	input  wire logic [tmr_od_pkg::IDX_W-1:0]  index,
	input  wire logic [tmr_od_pkg::DATA_W-1:0] write_data,
	input  wire logic                          done,
	input  wire logic [1:0]                    status,
	input  wire logic [tmr_od_pkg::DATA_W-1:0] read_data,
	input  wire logic [1:0]                    entry_state,
	input  wire logic                          vote_failed,
	output int                                 mismatches,
	output int                                 outstanding
);
	import tmr_od_pkg::*;

	typedef struct packed {
		status_t             status;
		logic [DATA_W-1:0]   data;
		mark_t               mark;
		logic                failed;
	} dict_result_t;

	logic [DATA_W-1:0] copy_a [MAX_ENTRIES];
	logic [DATA_W-1:0] copy_b [MAX_ENTRIES];
	logic [DATA_W-1:0] copy_c [MAX_ENTRIES];
	mark_t             marks  [MAX_ENTRIES];
	dict_result_t      pending_results [$];

	function automatic logic [DATA_W-1:0] byte_swap(input logic [DATA_W-1:0] x);
		return {x[7:0], x[15:8], x[23:16], x[31:24]};
	endfunction

	function automatic void store_entry(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] v);
		copy_a[idx] = v;
		copy_b[idx] = v;
		copy_c[idx] = v;
	endfunction

	// two-of-three vote with scrub; returns 1 when no two copies agree
	function automatic logic vote_scrub(input logic [IDX_W-1:0] idx);
		logic [DATA_W-1:0] a, b, c;
		a = copy_a[idx];
		b = copy_b[idx];
		c = copy_c[idx];
		if (a == b && a == c) return 1'b0;
		if (a == b) begin
			copy_c[idx] = a;
			return 1'b0;
		end
		if (a == c) begin
			copy_b[idx] = a;
			return 1'b0;
		end
		if (b == c) begin
			copy_a[idx] = b;
			return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic dict_result_t predict_access(input logic [2:0] cmd,
			input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] wdata);
		dict_result_t r;
		right_t rt;
		logic [DATA_W-1:0] v;
		logic [DATA_W-1:0] m;
		logic in_range;
		logic allowed;
		r = '{STATUS_OK, '0, MARK_UNTOUCHED, 1'b0};
		in_range = int'(idx) < ENTRY_COUNT;
		rt = (int'(idx) < TABLE_ROWS) ? right_t'(ACCESS_RIGHT[idx]) : RIGHT_NONE;
		if (cmd <= OP_TIME_SET && !in_range) begin
			r.status = STATUS_BAD_INDEX;
		end else begin
			case (cmd)
				OP_RAW_WRITE: store_entry(idx, wdata);
				OP_RAW_READ: begin
					m = 32'hFFFF_FFFF;
					if (int'(idx) < TABLE_ROWS) begin
						case (SIZE_CODE[idx])
							3'd0:    m = 32'h0000_0001;
							3'd1:    m = 32'h0000_0003;
							3'd2:    m = 32'h0000_0007;
							3'd3:    m = 32'h0000_00FF;
							3'd4:    m = 32'h0000_FFFF;
							3'd5:    m = 32'h00FF_FFFF;
							default: m = 32'hFFFF_FFFF;
						endcase
					end
					r.failed = vote_scrub(idx);
					r.data = copy_a[idx] & m;
				end
				OP_NET_WRITE, OP_TIME_SET: begin
					allowed = (cmd == OP_NET_WRITE) ?
						(rt == RIGHT_SET || rt == RIGHT_GET_AND_SET) : (rt == RIGHT_SETT);
					if (rt == RIGHT_NONE) begin
						r.status = STATUS_BAD_INDEX;
					end else if (!allowed) begin
						r.status = STATUS_BAD_RIGHT;
					end else begin
						v = byte_swap(wdata);
						r.failed = vote_scrub(idx);
						if (copy_a[idx] != v)
							marks[idx] = MARK_CHANGED;
						else if (marks[idx] != MARK_CHANGED)
							marks[idx] = MARK_WRITTEN;
						store_entry(idx, v);
					end
				end
				OP_NET_READ: begin
					if (rt == RIGHT_NONE) begin
						r.status = STATUS_BAD_INDEX;
					end else if (rt != RIGHT_GET && rt != RIGHT_GET_AND_SET) begin
						r.status = STATUS_BAD_RIGHT;
					end else begin
						r.failed = vote_scrub(idx);
						r.data = byte_swap(copy_a[idx]);
					end
				end
				default: ;
			endcase
		end
		if (in_range) r.mark = marks[idx];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		dict_result_t want;
		if (!arst_n) begin
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				case (i)
					'h00:    store_entry(IDX_W'(i), 32'd102);
					'h10:    store_entry(IDX_W'(i), 32'd1);
					'h1B:    store_entry(IDX_W'(i), 32'd3);
					'h1E:    store_entry(IDX_W'(i), 32'd1);
					'h1F:    store_entry(IDX_W'(i), 32'd1);
					'h25:    store_entry(IDX_W'(i), 32'd10);
					'h26:    store_entry(IDX_W'(i), 32'd120);
					'h27:    store_entry(IDX_W'(i), 32'd1);
					'h30:    store_entry(IDX_W'(i), 32'd30);
					default: store_entry(IDX_W'(i), 32'd0);
				endcase
				marks[i] = MARK_UNTOUCHED;
			end
			pending_results.delete();
			mismatches = 0;
			outstanding = 0;
		end else begin
			// retire first: a new transaction may be taken in the cycle of done
			if (done) begin
				if (pending_results.size() == 0) begin
					$error("result with no transaction outstanding");
					mismatches++;
				end else begin
					want = pending_results.pop_front();
					if (status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, status);
						mismatches++;
					end
					if (read_data !== want.data) begin
						$error("read_data: expected %h, got %h", want.data, read_data);
						mismatches++;
					end
					if (entry_state !== want.mark) begin
						$error("entry_state: expected %0d, got %0d", want.mark, entry_state);
						mismatches++;
					end
					if (vote_failed !== want.failed) begin
						$error("vote_failed: expected %0d, got %0d", want.failed, vote_failed);
						mismatches++;
					end
				end
			end
			if (start && !busy)
				pending_results.push_back(predict_access(op, index, write_data));
			outstanding = pending_results.size();
		end
	end

endmodule

[dv/tmr_object_dictionary_tb.sv]
// Testbench top of the object dictionary: drives transactions and reports the verdict.
module tmr_object_dictionary_tb;
	import tmr_od_pkg::*;

	localparam int CYCLE_LIMIT  = 100000;
	localparam int RANDOM_ITEMS = 500;
	localparam logic [2:0] OP_UNUSED_LO = 3'd5;
	localparam logic [2:0] OP_UNUSED_HI = 3'd7;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [2:0]        op;
	logic [IDX_W-1:0]  index;
	logic [DATA_W-1:0] write_data;
	logic              done;
	logic [1:0]        status;
	logic [DATA_W-1:0] read_data;
	logic [1:0]        entry_state;
	logic              vote_failed;
	int                mismatches;
	int                outstanding;
	int                cycles = 0;
	logic              burst = 1'b0;

	tmr_object_dictionary dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.op          (op),
		.index       (index),
		.write_data  (write_data),
		.done        (done),
		.status      (status),
		.read_data   (read_data),
		.entry_state (entry_state),
		.vote_failed (vote_failed)
	);

	tmr_od_result_check result_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.op          (op),
		.index       (index),
		.write_data  (write_data),
		.done        (done),
		.status      (status),
		.read_data   (read_data),
		.entry_state (entry_state),
		.vote_failed (vote_failed),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("[tmr_object_dictionary] ERROR");
			$finish;
		end
	end

	// Returns right after the edge that takes the transaction.
	task automatic issue(input logic [2:0] cmd, input logic [IDX_W-1:0] idx,
			input logic [DATA_W-1:0] wdata);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 5);
		repeat (gap) begin
			@(negedge clk);
			start = 1'b0;
			op = 3'($urandom);
			index = IDX_W'($urandom);
			write_data = $urandom;
		end
		@(negedge clk);
		start = 1'b1;
		op = cmd;
		index = idx;
		write_data = wdata;
		while (busy) @(negedge clk);
		@(posedge clk);
	endtask

	initial begin
		logic [2:0]        r_op;
		logic [IDX_W-1:0]  r_idx;
		logic [DATA_W-1:0] r_data;
		int                sel;
		arst_n = 1'b0;
		start = 1'b0;
		op = OP_RAW_WRITE;
		index = '0;
		write_data = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// defaults, masks, marks, rights, bad index, unused ops
		issue(OP_RAW_READ, 7'h00, 32'h0);
		issue(OP_NET_READ, 7'h10, 32'hFFFF_FFFF);
		issue(OP_NET_WRITE, 7'd12, 32'h0);
		issue(OP_NET_WRITE, 7'd12, 32'h0100_0000);
		issue(OP_NET_WRITE, 7'd12, 32'h0100_0000);
		issue(OP_RAW_READ, 7'd12, 32'h0);
		issue(OP_RAW_WRITE, 7'h00, 32'hFFFF_FFFF);
		issue(OP_RAW_READ, 7'h00, 32'h0);
		issue(OP_RAW_WRITE, 7'd1, 32'hFFFF_FFFF);
		issue(OP_RAW_READ, 7'd1, 32'h0);
		issue(OP_TIME_SET, 7'd1, 32'h1234_5678);
		issue(OP_NET_READ, 7'd1, 32'h0);
		issue(OP_NET_WRITE, 7'h00, 32'h5555_AAAA);
		issue(OP_TIME_SET, 7'h10, 32'h0);
		issue(OP_RAW_WRITE, 7'd98, 32'hFFFF_FFFF);
		issue(OP_RAW_READ, 7'd98, 32'h0);
		issue(OP_NET_READ, 7'd98, 32'h0);
		issue(OP_NET_WRITE, 7'd98, 32'hA5C3_0F81);
		issue(OP_RAW_WRITE, IDX_W'(ENTRY_COUNT), 32'hFFFF_FFFF);
		issue(OP_RAW_READ, IDX_W'(ENTRY_COUNT), 32'h0);
		issue(OP_NET_WRITE, 7'd127, 32'hFFFF_FFFF);
		issue(OP_NET_READ, 7'd127, 32'h0);
		issue(OP_TIME_SET, IDX_W'(ENTRY_COUNT), 32'h0);
		issue(OP_UNUSED_LO, 7'd16, 32'hFFFF_FFFF);
		issue(OP_UNUSED_HI, 7'd127, 32'hFFFF_FFFF);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if ($urandom_range(0, 31) == 0) burst = !burst;
			sel = $urandom_range(0, 99);
			r_op = (sel < 6) ? 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI))
			                 : 3'($urandom_range(OP_RAW_WRITE, OP_TIME_SET));
			// a few hot entries of each right so marks and rewrites repeat
			sel = $urandom_range(0, 99);
			if (sel < 10) begin
				r_idx = IDX_W'($urandom_range(ENTRY_COUNT, 127));
			end else if (sel < 40) begin
				case ($urandom_range(0, 5))
					0:       r_idx = 7'd0;
					1:       r_idx = 7'd1;
					2:       r_idx = 7'd12;
					3:       r_idx = 7'd16;
					4:       r_idx = 7'd35;
					default: r_idx = 7'd84;
				endcase
			end else begin
				r_idx = IDX_W'($urandom_range(0, ENTRY_COUNT - 1));
			end
			sel = $urandom_range(0, 99);
			if (sel < 35) begin
				case ($urandom_range(0, 3))
					0:       r_data = 32'h0000_0000;
					1:       r_data = 32'h0000_0001;
					2:       r_data = 32'h0100_0000;
					default: r_data = 32'hFFFF_FFFF;
				endcase
			end else begin
				r_data = $urandom;
			end
			issue(r_op, r_idx, r_data);
		end
		@(negedge clk);
		start = 1'b0;

		while (outstanding != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		if (mismatches == 0)
			$display("[tmr_object_dictionary] OK");
		else
			$display("[tmr_object_dictionary] ERROR");
		$finish;
	end

endmodule
